>>> design/lms_adaptive_fir_macros.svh
// ----------------------------------------------------------------------------
// lms adaptive fir assertion macros
// concurrent check shorthands shared by the controller and the datapath
// ----------------------------------------------------------------------------
`ifndef LMS_ADAPTIVE_FIR_MACROS_SVH
`define LMS_ADAPTIVE_FIR_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define LMSAF_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define LMSAF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/lmsaf_pkg.sv
// ----------------------------------------------------------------------------
// lms adaptive fir package
// widths, reset values and controller/datapath command and status types
// ----------------------------------------------------------------------------
package lmsaf_pkg;

   localparam int TAPS_DEFAULT = 16;

   localparam int SAMPLE_W   = 16;   // q1.15 sample and desired
   localparam int OUT_W      = 16;   // q2.14 filtered and error
   localparam int WEIGHT_W   = 32;   // q5.27 weights
   localparam int STEP_W     = 16;   // q0.16 step size
   localparam int MULA_W     = 33;   // shared multiplier operand a (weight or mu*e)
   localparam int PROD_W     = MULA_W + SAMPLE_W;
   localparam int Y_SHIFT    = 28;   // q.42 accumulator to q2.14
   localparam int D_SHIFT    = 27;   // q1.15 desired to q.42
   localparam int UPD_SHIFT  = 17;   // mu*e*x to q.27 with the factor of two

   localparam logic [STEP_W-1:0] STEP_RESET = 16'd328;

   typedef struct packed {
      logic load;     // item accepted: write sample, hold desired, clear acc
      logic rd_en;    // read history and weight at the walk addresses
      logic upd;      // walk is the weight update pass
      logic w_zero;   // weights of this run not written yet, read as zero
      logic calc;     // round and saturate y and e into the output register
      logic mue_ld;   // form mu*e for the update pass
   } lmsaf_cmd_type;

   typedef struct packed {
      logic pipe_busy;  // multiply pipeline still holds a tap
      logic out_free;   // output register can take a new result
   } lmsaf_sts_type;

endpackage

>>> design/lmsaf_ctrl.sv
// ----------------------------------------------------------------------------
// lms adaptive fir controller
// run bookkeeping, tap walks and sequencing of the shared multiply-accumulate
// ----------------------------------------------------------------------------
`include "lms_adaptive_fir_macros.svh"

module lmsaf_ctrl import lmsaf_pkg::*; #(
   parameter int TAPS = TAPS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_first,
   output logic                       req_ready,
   input  lmsaf_sts_type              sts,
   output lmsaf_cmd_type              cmd,
   output logic [$clog2(TAPS)-1:0]    hist_waddr,
   output logic [$clog2(TAPS)-1:0]    hist_raddr,
   output logic [$clog2(TAPS)-1:0]    tap
);

   localparam int IW = $clog2(TAPS);
   localparam int FW = $clog2(TAPS + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(TAPS - 1);
   localparam logic [FW-1:0] FILL_FULL = FW'(TAPS);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MAC    = 3'd1;
   localparam logic [2:0] S_MDRAIN = 3'd2;
   localparam logic [2:0] S_CALC   = 3'd3;
   localparam logic [2:0] S_MUE    = 3'd4;
   localparam logic [2:0] S_UPD    = 3'd5;
   localparam logic [2:0] S_UDRAIN = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [IW-1:0] ptr_ff, ptr_in;
   logic [IW-1:0] hidx_ff, hidx_in;
   logic [IW-1:0] tap_ff, tap_in;
   logic          wvalid_ff, wvalid_in;
   logic [IW-1:0] ptr_next;
   logic [FW-1:0] fill_base;

   assign req_ready  = (state_ff == S_IDLE);
   assign hist_raddr = hidx_ff;
   assign tap        = tap_ff;
   assign ptr_next   = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
   assign hist_waddr = ptr_next;
   assign fill_base  = req_first ? '0 : fill_ff;

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      ptr_in    = ptr_ff;
      hidx_in   = hidx_ff;
      tap_in    = tap_ff;
      wvalid_in = wvalid_ff;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               ptr_in   = ptr_next;
               if (req_first) begin
                  wvalid_in = 1'b0;
               end
               if (fill_base < FILL_FULL) begin
                  fill_in = fill_base + 1'b1;
               end else begin
                  fill_in  = fill_base;
                  hidx_in  = ptr_next;
                  tap_in   = '0;
                  state_in = S_MAC;
               end
            end
         end
         S_MAC, S_UPD: begin
            cmd.rd_en  = 1'b1;
            cmd.upd    = (state_ff == S_UPD);
            cmd.w_zero = !wvalid_ff;
            hidx_in    = (hidx_ff == '0) ? LAST_IDX : hidx_ff - 1'b1;
            tap_in     = tap_ff + 1'b1;
            if (tap_ff == LAST_IDX) begin
               state_in = (state_ff == S_UPD) ? S_UDRAIN : S_MDRAIN;
            end
         end
         S_MDRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            if (sts.out_free) begin
               cmd.calc = 1'b1;
               state_in = S_MUE;
            end
         end
         S_MUE: begin
            cmd.mue_ld = 1'b1;
            hidx_in    = ptr_ff;
            tap_in     = '0;
            state_in   = S_UPD;
         end
         S_UDRAIN: begin
            if (!sts.pipe_busy) begin
               wvalid_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         fill_ff   <= '0;
         ptr_ff    <= '0;
         hidx_ff   <= '0;
         tap_ff    <= '0;
         wvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         ptr_ff    <= ptr_in;
         hidx_ff   <= hidx_in;
         tap_ff    <= tap_in;
         wvalid_ff <= wvalid_in;
      end
   end

   // results are formed only from a fully drained accumulation
   `LMSAF_ASSERT_IMPL(a_calc_drained, cmd.calc, !sts.pipe_busy, "calc with taps in flight")
   // the fill count never passes the tap count
   `LMSAF_ASSERT_IMPL(a_fill_range, 1'b1, fill_ff <= FILL_FULL, "fill count out of range")

endmodule

>>> design/lmsaf_dp.sv
// ----------------------------------------------------------------------------
// lms adaptive fir datapath
// history and weight memories, shared multiplier, accumulator, output register
// ----------------------------------------------------------------------------
`include "lms_adaptive_fir_macros.svh"

module lmsaf_dp import lmsaf_pkg::*; #(
   parameter int TAPS = TAPS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lmsaf_cmd_type               cmd,
   output lmsaf_sts_type               sts,
   input  logic [$clog2(TAPS)-1:0]     hist_waddr,
   input  logic [$clog2(TAPS)-1:0]     hist_raddr,
   input  logic [$clog2(TAPS)-1:0]     tap,
   input  logic signed [SAMPLE_W-1:0]  sample,
   input  logic signed [SAMPLE_W-1:0]  desired,
   input  logic                        csr_wen,
   input  logic [STEP_W-1:0]           csr_wdata,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [OUT_W-1:0]     rsp_filtered,
   output logic signed [OUT_W-1:0]     rsp_error
);

   localparam int IW   = $clog2(TAPS);
   localparam int AW   = PROD_W + IW;      // accumulator
   localparam int RW   = AW + 2;           // error and rounding headroom
   localparam int DW   = PROD_W + 1;       // rounded update product
   localparam int SW   = WEIGHT_W + 2;     // weight sum before saturation
   localparam logic signed [RW-1:0] HALF_Y   = RW'(1) <<< (Y_SHIFT - 1);
   localparam logic signed [DW-1:0] HALF_UPD = DW'(1) <<< (UPD_SHIFT - 1);

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [RW-1:0] v);
      logic signed [OUT_W-1:0] r;
      if ((v[RW-1:OUT_W-1] == '0) || (v[RW-1:OUT_W-1] == '1)) begin
         r = v[OUT_W-1:0];
      end else begin
         r = v[RW-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
      end
      return r;
   endfunction

   logic signed [SAMPLE_W-1:0] hist_mem [TAPS];
   logic signed [WEIGHT_W-1:0] w_mem    [TAPS];

   logic [STEP_W-1:0]          step_ff;
   logic signed [SAMPLE_W-1:0] desired_ff;
   logic signed [SAMPLE_W-1:0] hist_rd_ff;
   logic signed [WEIGHT_W-1:0] w_rd_ff;
   logic signed [MULA_W-1:0]   mue_ff;

   logic          s1_valid_ff, s1_upd_ff, s1_wzero_ff;
   logic [IW-1:0] s1_tap_ff;
   logic          s2_valid_ff, s2_upd_ff;
   logic [IW-1:0] s2_tap_ff;
   logic signed [WEIGHT_W-1:0] s2_w_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [AW-1:0]       acc_ff;

   logic                       rsp_valid_ff;
   logic signed [OUT_W-1:0]    filt_ff, err_ff;

   logic signed [WEIGHT_W-1:0] w_eff;
   logic signed [MULA_W-1:0]   mul_a;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [DW-1:0]       upd_round;
   logic signed [DW-1:0]       delta;
   logic signed [SW-1:0]       w_sum;
   logic signed [WEIGHT_W-1:0] w_new;
   logic                       w_we;
   logic signed [RW-1:0]       acc_ext, y_round, e_acc, e_round;
   logic signed [MULA_W-1:0]   mue_in;

   // stage one: one shared multiplier, weight for y or mu*e for the update
   assign w_eff   = s1_wzero_ff ? '0 : w_rd_ff;
   assign mul_a   = s1_upd_ff ? mue_ff : MULA_W'(w_eff);
   assign prod_in = mul_a * hist_rd_ff;

   // stage two: round the update step and saturate the new weight
   assign upd_round = DW'(prod_ff) + HALF_UPD;
   assign delta     = upd_round >>> UPD_SHIFT;
   assign w_sum     = SW'(s2_w_ff) + SW'(delta);
   assign w_we      = s2_valid_ff && s2_upd_ff;
   always_comb begin
      if ((w_sum[SW-1:WEIGHT_W-1] == '0) || (w_sum[SW-1:WEIGHT_W-1] == '1)) begin
         w_new = w_sum[WEIGHT_W-1:0];
      end else begin
         w_new = w_sum[SW-1] ? {1'b1, {(WEIGHT_W-1){1'b0}}} : {1'b0, {(WEIGHT_W-1){1'b1}}};
      end
   end

   // output rounding of y and e
   assign acc_ext = RW'(acc_ff);
   assign y_round = (acc_ext + HALF_Y) >>> Y_SHIFT;
   assign e_acc   = (RW'(desired_ff) <<< D_SHIFT) - acc_ext;
   assign e_round = (e_acc + HALF_Y) >>> Y_SHIFT;
   assign mue_in  = $signed({1'b0, step_ff}) * err_ff;

   assign sts.pipe_busy = s1_valid_ff || s2_valid_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filtered  = filt_ff;
   assign rsp_error     = err_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hist_mem[hist_waddr] <= sample;
      end
      if (cmd.rd_en) begin
         hist_rd_ff <= hist_mem[hist_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         w_mem[s2_tap_ff] <= w_new;
      end
      if (cmd.rd_en) begin
         w_rd_ff <= w_mem[tap];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_RESET;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            step_ff <= csr_wdata;
         end
         s1_valid_ff <= cmd.rd_en;
         s2_valid_ff <= s1_valid_ff;
         if (cmd.calc) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_upd_ff   <= cmd.upd;
      s1_wzero_ff <= cmd.w_zero;
      s1_tap_ff   <= tap;
      s2_upd_ff   <= s1_upd_ff;
      s2_tap_ff   <= s1_tap_ff;
      s2_w_ff     <= w_eff;
      prod_ff     <= prod_in;
      if (cmd.load) begin
         desired_ff <= desired;
         acc_ff     <= '0;
      end else if (s2_valid_ff && !s2_upd_ff) begin
         acc_ff <= acc_ff + AW'(prod_ff);
      end
      if (cmd.calc) begin
         filt_ff <= sat_out(y_round);
         err_ff  <= sat_out(e_round);
      end
      if (cmd.mue_ld) begin
         mue_ff <= mue_in;
      end
   end

   // a result shows up only right after the controller asked for one
   `LMSAF_ASSERT_IMPL(a_rsp_from_calc, $rose(rsp_valid_ff), $past(cmd.calc), "result without calc")
   // a new item never lands on a walk still in the pipeline
   `LMSAF_ASSERT_IMPL(a_load_idle, cmd.load, !sts.pipe_busy, "load during tap walk")
   // forming the step product is always followed by the update pass
   `LMSAF_ASSERT_NEXT(a_mue_then_upd, cmd.mue_ld, cmd.rd_en && cmd.upd, "update without mu*e")

endmodule

>>> design/lms_adaptive_fir.sv
// ----------------------------------------------------------------------------
// lms adaptive fir
// least-mean-squares adaptive fir filter with a shared multiply-accumulate
// ----------------------------------------------------------------------------
// Each req item carries one q1.15 input sample, one q1.15 desired sample and a
// run-start flag in tuser. The flag clears the weights, the sample history and
// the fill count, and the sample with it counts as the first of the new run.
// The first TAPS samples of a run only fill the history and
// return no item. Every later item returns one rsp item with the filter output
// y and the error e = desired - y, both q2.14, rounded and saturated, and then
// adapts all weights by 2*mu*e*x in q5.27. For a result item one multiplier
// walks the TAPS weight and sample products for y, the pipeline drains, y and
// e are rounded into the rsp register, mu*e is formed, then the multiplier
// walks the TAPS weight updates and the pipeline drains again. Items are taken
// one at a time; the next item is accepted while a result still waits in the
// rsp register. History lives in a circular buffer and weights in a
// single-port-read memory; neither needs a clearing pass. The step size mu
// (unsigned q0.16, reset 328) is written through csr_wen and csr_wdata; the
// user writes it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module lms_adaptive_fir import lmsaf_pkg::*; #(
   parameter int TAPS = TAPS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   // input items
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // sample [15:0], desired [31:16]
   input  logic [0:0]           req_tuser,   // first_sample [0]
   // result items
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // filtered [15:0], error [31:16]
   // step size register
   input  logic                 csr_wen,
   input  logic [STEP_W-1:0]    csr_wdata
);

   localparam int IW = $clog2(TAPS);

   lmsaf_cmd_type cmd;
   lmsaf_sts_type sts;
   logic [IW-1:0] hist_waddr;
   logic [IW-1:0] hist_raddr;
   logic [IW-1:0] tap;
   logic signed [OUT_W-1:0] rsp_filtered;
   logic signed [OUT_W-1:0] rsp_error;

   // unpack and pack the stream payloads
   assign rsp_tdata = {rsp_error, rsp_filtered};

   // controller: run state, fill count, buffer pointer and tap walks
   lmsaf_ctrl #(
      .TAPS (TAPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_first  (req_tuser[0]),
      .req_ready  (req_tready),
      .sts        (sts),
      .cmd        (cmd),
      .hist_waddr (hist_waddr),
      .hist_raddr (hist_raddr),
      .tap        (tap)
   );

   // datapath: memories, shared multiplier, accumulator, rounding, rsp register
   lmsaf_dp #(
      .TAPS (TAPS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .hist_waddr   (hist_waddr),
      .hist_raddr   (hist_raddr),
      .tap          (tap),
      .sample       (req_tdata[15:0]),
      .desired      (req_tdata[31:16]),
      .csr_wen      (csr_wen),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_filtered (rsp_filtered),
      .rsp_error    (rsp_error)
   );

endmodule

>>> test/lms_adaptive_fir_chk.sv
// ----------------------------------------------------------------------------
// lms adaptive fir checker
// watches the req, rsp and csr ports, predicts every rsp item from its own
// copy of the filter state and compares the two field by field
// ----------------------------------------------------------------------------
module lms_adaptive_fir_chk import lmsaf_pkg::*; #(
   parameter int TAPS = TAPS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [31:0]         req_tdata,   // sample [15:0], desired [31:16]
   input  logic [0:0]          req_tuser,   // first_sample [0]
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [31:0]         rsp_tdata,   // filtered [15:0], error [31:16]
   input  logic                csr_wen,
   input  logic [STEP_W-1:0]   csr_wdata,
   output int                  fail_count,
   output int                  pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // packed so that filtered lands in the low half, as on rsp_tdata
   typedef struct packed {
      logic signed [OUT_W-1:0] error;
      logic signed [OUT_W-1:0] filtered;
   } fir_out_type;

   logic signed [SAMPLE_W-1:0] delay_line [TAPS];
   logic signed [WEIGHT_W-1:0] coeffs [TAPS];
   int                         samples_in_run;
   logic [STEP_W-1:0]          mu;
   fir_out_type                fir_results_q [$];
   int                         fails = 0;

   function automatic longint round_down_shift(input longint v, input int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic clear_run();
      int k;
      for (k = 0; k < TAPS; k++) begin
         delay_line[k] = '0;
         coeffs[k] = '0;
      end
      samples_in_run = 0;
   endtask

   // one lms step: shift in x, filter, then adapt every weight by 2*mu*e*x
   task automatic lms_advance(input logic signed [SAMPLE_W-1:0] x,
                              input logic signed [SAMPLE_W-1:0] d,
                              input logic start,
                              output logic produced,
                              output fir_out_type r);
      int k;
      longint acc, y, e, p, w;
      produced = 1'b0;
      r = '0;
      if (start) clear_run();
      for (k = TAPS - 1; k > 0; k--) delay_line[k] = delay_line[k-1];
      delay_line[0] = x;
      if (samples_in_run < TAPS) begin
         samples_in_run++;
         return;
      end
      acc = 0;
      for (k = 0; k < TAPS; k++) acc += longint'(coeffs[k]) * longint'(delay_line[k]);
      y = clamp(round_down_shift(acc, Y_SHIFT), -32768, 32767);
      e = clamp(round_down_shift((longint'(d) <<< D_SHIFT) - acc, Y_SHIFT), -32768, 32767);
      for (k = 0; k < TAPS; k++) begin
         p = longint'(mu) * e * longint'(delay_line[k]);
         w = longint'(coeffs[k]) + round_down_shift(p, UPD_SHIFT);
         coeffs[k] = WEIGHT_W'(clamp(w, -(longint'(1) <<< 31), (longint'(1) <<< 31) - 1));
      end
      r.filtered = OUT_W'(y);
      r.error = OUT_W'(e);
      produced = 1'b1;
   endtask

   always @(posedge clock) begin
      fir_out_type seen, want, r;
      logic produced;
      if (reset) begin
         clear_run();
         mu = STEP_RESET;
         fir_results_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (fir_results_q.size() == 0) begin
               $display("%0t: unexpected rsp item, expected none, actual filtered %0d error %0d",
                        $time, seen.filtered, seen.error);
               fails++;
            end else begin
               want = fir_results_q.pop_front();
               if (seen.filtered !== want.filtered) begin
                  $display("%0t: filtered mismatch, expected %0d, actual %0d",
                           $time, want.filtered, seen.filtered);
                  fails++;
               end
               if (seen.error !== want.error) begin
                  $display("%0t: error mismatch, expected %0d, actual %0d",
                           $time, want.error, seen.error);
                  fails++;
               end
            end
         end
         if (csr_wen) mu = csr_wdata;
         if (req_tvalid && req_tready) begin
            lms_advance(req_tdata[15:0], req_tdata[31:16], req_tuser[0], produced, r);
            if (produced) fir_results_q.push_back(r);
         end
      end
      fail_count <= fails;
      pending <= fir_results_q.size();
   end

endmodule

>>> test/lms_adaptive_fir_tb.sv
// ----------------------------------------------------------------------------
// lms adaptive fir testbench
// drives sample runs through the filter under several step sizes and idle
// patterns, with a long rsp hold-off, while the checker predicts every result
// ----------------------------------------------------------------------------
module lms_adaptive_fir_tb import lmsaf_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TAPS = TAPS_DEFAULT;
   // long enough to cover any result item still in flight
   localparam int SETTLE = 2 * TAPS + 30;
   // long enough for the rsp register and the next result to fill up
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 220;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [31:0]         req_tdata = '0;   // sample [15:0], desired [31:16]
   logic [0:0]          req_tuser = '0;   // first_sample [0]
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [31:0]         rsp_tdata;        // filtered [15:0], error [31:16]
   logic                csr_wen = 1'b0;
   logic [STEP_W-1:0]   csr_wdata = '0;

   int fail_count;
   int pending;

   // idle percentages for the sender and the receiver, set per phase
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   // each bump of hold_ask asks the receiver for one long hold-off
   int hold_ask = 0;
   int hold_seen = 0;

   always #6 clock = ~clock;

   lms_adaptive_fir uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   lms_adaptive_fir_chk #(.TAPS(TAPS)) chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // receiver: random stalls, plus a long hold-off whenever one is asked for
   initial begin
      forever begin
         @(posedge clock);
         if (hold_seen != hold_ask) begin
            hold_seen = hold_ask;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // offer one item, with random idle cycles first, and wait until it is taken
   task automatic send_item(input logic [15:0] s, input logic [15:0] d, input logic first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {d, s};
      req_tuser <= first;
      do @(posedge clock); while (!req_tready);
   endtask

   // the block is idle once no result is owed and any fill item has drained
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_step(input logic [STEP_W-1:0] v);
      csr_wen <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   // sample values by flavor: full range, corner values, small signal
   function automatic logic [15:0] pick_value(input int mode);
      int v;
      case (mode)
         1: begin
            case ($urandom_range(5))
               0: return 16'h8000;
               1: return 16'h7fff;
               2: return 16'h0000;
               3: return 16'hffff;
               4: return 16'h0001;
               default: return 16'($urandom);
            endcase
         end
         2: begin
            v = $urandom_range(511);
            return 16'(v - 256);
         end
         default: return 16'($urandom);
      endcase
   endfunction

   // mostly whole runs (start flag, fill, results), some runs cut short
   // during the fill, and some noise with the start flag at random
   task automatic send_runs(input int total, input bit with_hold);
      int sent, len, kind, mode, k, hold_at;
      logic signed [15:0] s, d, s1, s2, s3;
      logic first;
      sent = 0;
      hold_at = with_hold ? total / 2 : -1;
      s1 = '0;
      s2 = '0;
      s3 = '0;
      while (sent < total) begin
         kind = $urandom_range(99);
         mode = $urandom_range(3);
         if (kind < 75) len = $urandom_range(TAPS + 1, TAPS + 70);
         else if (kind < 88) len = $urandom_range(1, TAPS - 1);
         else len = $urandom_range(1, 8);
         for (k = 0; k < len && sent < total; k++) begin
            s = pick_value(mode);
            // mode 3: desired is a fixed fir of the input, so the weights converge
            if (mode == 3) d = (s1 >>> 1) + (s3 >>> 2);
            else d = pick_value(mode);
            if (kind < 88) first = (k == 0);
            else first = ($urandom_range(99) < 30);
            if (sent == hold_at) hold_ask++;
            send_item(s, d, first);
            s3 = s2;
            s2 = s1;
            s1 = s;
            sent++;
         end
      end
   endtask

   task automatic run_phase(input logic [STEP_W-1:0] step, input int idle, input int stall,
                            input bit with_hold);
      wait_idle();
      write_step(step);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      send_runs(PHASE_ITEMS, with_hold);
   endtask

   initial begin
      int i;
      logic [15:0] s;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // no run started yet: the first TAPS items fill the history, at reset mu
      for (i = 0; i < TAPS; i++) begin
         s = (i % 3 == 0) ? 16'h8000 : (i % 3 == 1) ? 16'h7fff : 16'h0000;
         send_item(s, ~s, 1'b0);
      end
      // first results, corner samples and desired values
      send_item(16'h8000, 16'h7fff, 1'b0);
      send_item(16'h7fff, 16'h8000, 1'b0);
      send_item(16'h0000, 16'h0000, 1'b0);
      send_item(16'h8000, 16'h8000, 1'b0);
      // start flag in the middle of a run
      send_item(16'h7fff, 16'h7fff, 1'b1);
      send_item(16'h0001, 16'hffff, 1'b0);
      send_item(16'hffff, 16'h0001, 1'b0);
      // start flag in the middle of the fill
      send_item(16'h5555, 16'haaaa, 1'b1);

      // step size sweep, extremes included, across the idle patterns
      run_phase(STEP_RESET, 0, 0, 1'b0);
      run_phase(16'd0, 51, 0, 1'b0);
      run_phase(16'hffff, 0, 51, 1'b1);
      run_phase(16'd1, 22, 22, 1'b0);
      run_phase(16'($urandom), 0, 0, 1'b1);
      run_phase(16'd8000, 22, 22, 1'b0);

      wait_idle();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog, far beyond the slowest passing run
   initial begin
      #10ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
